// ===== design/lsag_pkg.sv =====
`timescale 1ns / 1ps

package lsag_pkg;

    // Stream widths; the data widths are padded to whole bytes.
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;

    // Entry selector carried in the input tuser.
    localparam logic [1:0] FUNC_SINGLE   = 2'd0;
    localparam logic [1:0] FUNC_MULTIPLE = 2'd1;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_ABORT = 2'd1;
    localparam logic [1:0] FAULT_UNDEF = 2'd2;

    // Access sizes.
    localparam logic [1:0] SIZE_WORD = 2'd0;
    localparam logic [1:0] SIZE_BYTE = 2'd1;
    localparam logic [1:0] SIZE_HALF = 2'd2;

    // Shift kinds of a scaled register offset.
    localparam logic [1:0] SHIFT_LSL = 2'd0;
    localparam logic [1:0] SHIFT_LSR = 2'd1;
    localparam logic [1:0] SHIFT_ASR = 2'd2;
    localparam logic [1:0] SHIFT_ROR = 2'd3;

    // Encoding constants.
    localparam logic [3:0] HALF_MARK = 4'b1011;
    localparam logic [3:0] REG_PC    = 4'd15;
    localparam logic [2:0] OP_HALF   = 3'b000;
    localparam logic [2:0] OP_IMM    = 3'b010;
    localparam logic [2:0] OP_REG    = 3'b011;

    // One result item without its last flag, valid flag in the lowest bit.
    typedef struct packed {
        logic [1:0]  fault;
        logic [31:0] writeback_value;
        logic        base_writeback;
        logic [3:0]  reg_index;
        logic [31:0] transfer_address;
        logic [1:0]  access_size;
        logic        is_load;
        logic        transfer_valid;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic decode;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic burst;
        logic final_reg;
    } stat_t;

endpackage

// ===== design/lsag_datapath.sv =====
`timescale 1ns / 1ps

module lsag_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsag_pkg::cmd_t                    cmd,
    output lsag_pkg::stat_t                   stat,
    input  logic [lsag_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [lsag_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lsag_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    // Captured input item.
    logic [1:0]  func_reg;
    logic [31:0] ins_reg;
    logic [31:0] base_reg;
    logic [31:0] off_reg;
    logic        carry_reg;
    logic        spsr_reg;
    logic [31:0] base_in;

    // Output register.
    logic                out_valid_reg;
    logic                out_valid_next;
    lsag_pkg::result_t   out_res_reg;
    logic                out_last_reg;

    // Register-list walk of a multiple transfer.
    logic [15:0] mask_reg;
    logic [15:0] mask_next;
    logic [31:0] baddr_reg;
    logic [31:0] baddr_next;
    logic        bload_reg;
    logic        bwb_reg;
    logic [31:0] bwbv_reg;

    // The program counter reads eight ahead when it is the base of a single transfer.
    always_comb
    begin
        base_in = s_tdata[63:32];
        if (s_tuser == lsag_pkg::FUNC_SINGLE && s_tdata[19:16] == lsag_pkg::REG_PC)
        begin
            base_in = s_tdata[63:32] + 32'd8;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= s_tuser;
            ins_reg   <= s_tdata[31:0];
            base_reg  <= base_in;
            off_reg   <= s_tdata[95:64];
            carry_reg <= s_tdata[96];
            spsr_reg  <= s_tdata[97];
        end
    end

    // Scaled register offset.
    logic [4:0]  amt;
    logic [1:0]  kind;
    logic [63:0] rot2;
    logic [31:0] shifted;

    assign amt  = ins_reg[11:7];
    assign kind = ins_reg[6:5];
    assign rot2 = {off_reg, off_reg} >> amt;

    always_comb
    begin
        case (kind)
            lsag_pkg::SHIFT_LSL: shifted = off_reg << amt;
            lsag_pkg::SHIFT_LSR: shifted = (amt == 5'd0) ? 32'd0 : (off_reg >> amt);
            lsag_pkg::SHIFT_ASR:
            begin
                if (amt == 5'd0)
                begin
                    shifted = {32{off_reg[31]}};
                end
                else
                begin
                    shifted = $unsigned($signed(off_reg) >>> amt);
                end
            end
            default: shifted = (amt == 5'd0) ? {carry_reg, off_reg[31:1]} : rot2[31:0];
        endcase
    end

    // Single transfer decode and address.
    logic [2:0]  op;
    logic        half;
    logic        op_ok;
    logic        imm;
    logic [3:0]  rn;
    logic [3:0]  rm;
    logic [31:0] offset;
    logic [31:0] sum;
    logic [31:0] s_addr;
    logic        s_wb;
    logic        s_abort;
    lsag_pkg::result_t single_res;

    assign op    = ins_reg[27:25];
    assign half  = (op == lsag_pkg::OP_HALF);
    assign op_ok = (half && ins_reg[7:4] == lsag_pkg::HALF_MARK)
                   || op == lsag_pkg::OP_IMM || op == lsag_pkg::OP_REG;
    assign imm   = half ? ins_reg[22] : !ins_reg[25];
    assign rn    = ins_reg[19:16];
    assign rm    = ins_reg[3:0];

    always_comb
    begin
        if (imm)
        begin
            offset = half ? {24'd0, ins_reg[11:8], ins_reg[3:0]} : {20'd0, ins_reg[11:0]};
        end
        else if (!half && ins_reg[11:4] != 8'd0)
        begin
            offset = shifted;
        end
        else
        begin
            offset = off_reg;
        end
    end

    // Bit 24 is P, bit 23 is U, bit 21 is W.
    assign sum    = ins_reg[23] ? (base_reg + offset) : (base_reg - offset);
    assign s_addr = ins_reg[24] ? sum : base_reg;
    assign s_wb   = !ins_reg[24] || ins_reg[21];

    always_comb
    begin
        s_abort = 1'b0;
        if (!imm && rm == lsag_pkg::REG_PC)
        begin
            s_abort = 1'b1;
        end
        if (s_wb && (rn == lsag_pkg::REG_PC || (!imm && rn == rm)))
        begin
            s_abort = 1'b1;
        end
        // Translated forms are not supported.
        if (!ins_reg[24] && ins_reg[21])
        begin
            s_abort = 1'b1;
        end
        if (half && s_addr[0])
        begin
            s_abort = 1'b1;
        end
    end

    // Multiple transfer setup.
    logic [4:0]  n_regs;
    logic [31:0] span;
    logic [31:0] m_opnd;
    logic [31:0] m_start;
    logic [31:0] m_wbv;
    logic        m_abort;

    always_comb
    begin
        n_regs = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            n_regs = n_regs + {4'd0, ins_reg[i]};
        end
    end

    assign span = {25'd0, n_regs, 2'b00};

    always_comb
    begin
        case (ins_reg[24:23])
            2'b01:   m_opnd = 32'd0;
            2'b11:   m_opnd = 32'd4;
            2'b00:   m_opnd = 32'd4 - span;
            default: m_opnd = 32'd0 - span;
        endcase
    end

    assign m_start = base_reg + m_opnd;
    assign m_wbv   = ins_reg[23] ? (base_reg + span) : (base_reg - span);
    assign m_abort = ins_reg[22] && !spsr_reg;

    // Result of an item that yields exactly one result.
    always_comb
    begin
        single_res = '0;
        if (func_reg == lsag_pkg::FUNC_SINGLE)
        begin
            if (!op_ok)
            begin
                single_res.fault = lsag_pkg::FAULT_UNDEF;
            end
            else if (s_abort)
            begin
                single_res.fault = lsag_pkg::FAULT_ABORT;
            end
            else
            begin
                single_res.transfer_valid   = 1'b1;
                single_res.is_load          = ins_reg[20];
                single_res.access_size      = half ? lsag_pkg::SIZE_HALF
                                              : (ins_reg[22] ? lsag_pkg::SIZE_BYTE
                                                             : lsag_pkg::SIZE_WORD);
                single_res.transfer_address = s_addr;
                single_res.reg_index        = ins_reg[15:12];
                single_res.base_writeback   = s_wb;
                single_res.writeback_value  = s_wb ? sum : 32'd0;
            end
        end
        else if (func_reg == lsag_pkg::FUNC_MULTIPLE)
        begin
            if (m_abort)
            begin
                single_res.fault = lsag_pkg::FAULT_ABORT;
            end
            else
            begin
                // Empty register list: no transfer, optional writeback.
                single_res.base_writeback  = ins_reg[21];
                single_res.writeback_value = ins_reg[21] ? m_wbv : 32'd0;
            end
        end
        else
        begin
            single_res.fault = lsag_pkg::FAULT_UNDEF;
        end
    end

    // Lowest listed register still to go.
    logic [3:0]  low_idx;
    logic [15:0] mask_rest;
    lsag_pkg::result_t burst_res;

    always_comb
    begin
        low_idx = 4'd0;
        for (int i = 15; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_idx = 4'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 16'd1);

    always_comb
    begin
        burst_res                  = '0;
        burst_res.transfer_valid   = 1'b1;
        burst_res.is_load          = bload_reg;
        burst_res.access_size      = lsag_pkg::SIZE_WORD;
        burst_res.transfer_address = baddr_reg;
        burst_res.reg_index        = low_idx;
        burst_res.base_writeback   = bwb_reg;
        burst_res.writeback_value  = bwb_reg ? bwbv_reg : 32'd0;
        burst_res.fault            = lsag_pkg::FAULT_NONE;
    end

    // Status to the controller.
    assign stat.out_free  = !out_valid_reg || m_tready;
    assign stat.burst     = (func_reg == lsag_pkg::FUNC_MULTIPLE) && !m_abort
                            && (ins_reg[15:0] != 16'd0);
    assign stat.final_reg = (mask_rest == 16'd0);

    // Walk and output-valid next values.
    always_comb
    begin
        mask_next  = mask_reg;
        baddr_next = baddr_reg;
        if (cmd.decode && stat.burst)
        begin
            mask_next  = ins_reg[15:0];
            baddr_next = m_start;
        end
        else if (cmd.emit)
        begin
            mask_next  = mask_rest;
            baddr_next = baddr_reg + 32'd4;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if ((cmd.decode && !stat.burst) || cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mask_reg      <= 16'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        baddr_reg <= baddr_next;
        if (cmd.decode && stat.burst)
        begin
            bload_reg <= ins_reg[20];
            bwb_reg   <= ins_reg[21];
            bwbv_reg  <= m_wbv;
        end
        if (cmd.decode && !stat.burst)
        begin
            out_res_reg  <= single_res;
            out_last_reg <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_res_reg  <= burst_res;
            out_last_reg <= stat.final_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lsag_pkg::OUT_DATA_W - $bits(lsag_pkg::result_t)){1'b0}}, out_res_reg};
    assign m_tlast  = out_last_reg;

    // A register-list step is taken only while registers remain in the list.
    a_emit_has_reg: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (mask_reg != 16'd0))
        else $error("register walk stepped with an empty list");

    // A waiting result is never overwritten; a list setup leaves the output register alone.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !((cmd.decode && !stat.burst) || cmd.emit))
        else $error("output register loaded while a result waits");

    // A faulting result ends its instruction and carries no transfer.
    a_fault_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.fault != lsag_pkg::FAULT_NONE)
        |-> (out_last_reg && !out_res_reg.transfer_valid))
        else $error("fault result without last or with a transfer");

endmodule

// ===== design/lsag_ctrl.sv =====
`timescale 1ns / 1ps

module lsag_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lsag_pkg::stat_t  stat,
    output lsag_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DECODE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequencing: take an item, decode it, then walk a register list if there is one.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.out_free || stat.burst)
                begin
                    cmd.decode = 1'b1;
                    state_next = stat.burst ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.final_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted item always moves the sequencer to the decode state.
    a_capture_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_DECODE))
        else $error("accepted item not followed by decode");

    // Commands are mutually exclusive.
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.decode, cmd.emit}))
        else $error("more than one datapath command at once");

    // The final register of a list returns the sequencer to idle.
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.final_reg) |=> (state_reg == ST_IDLE))
        else $error("register walk did not end after its final register");

endmodule

// ===== design/load_store_address_generator.sv =====
`timescale 1ns / 1ps
// Sequence: an accepted item is captured, then decoded; the decode loads one result into
// the output register, or starts the register-list walk, which loads one result per
// listed register as the output register frees. A new item is taken only once the
// sequencer is back in idle, after the decode or after the final register of a list.
// Reset: rst_n clears the sequencer, the output valid flag and the register-list mask; the captured item is not reset.

module load_store_address_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // instr, base_value, offset_value, carry_flag, mode_has_spsr, zero padding
    input  logic [lsag_pkg::IN_DATA_W-1:0]    s_tdata,
    // func
    input  logic [lsag_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // transfer_valid, is_load, access_size, transfer_address, reg_index,
    // base_writeback, writeback_value, fault, zero padding
    output logic [lsag_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);

    lsag_pkg::cmd_t  cmd;
    lsag_pkg::stat_t stat;

    // Sequencer.
    lsag_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Decode, address arithmetic and output register.
    lsag_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== tb/tb_load_store_address_generator.sv =====
`timescale 1ns / 1ps

module tb_load_store_address_generator;

    // Entry selectors that the block rejects; the package only names the two it serves.
    localparam logic [1:0] FUNC_COPROC   = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam int RANDOM_ITEMS = 205;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;

    // One load/store instruction as the sender presents it.
    typedef struct packed {
        logic [1:0]  fn;
        logic [31:0] ins;
        logic [31:0] base;
        logic [31:0] rmv;
        logic        carry;
        logic        spsr;
    } ls_instr_t;

    // One memory transfer as the block should report it.
    typedef struct packed {
        lsag_pkg::result_t res;
        logic              last;
    } transfer_t;

    // A directed row; typed rows carry the fault code that the row must produce.
    typedef struct packed {
        ls_instr_t  item;
        logic       typed;
        logic [1:0] typed_fault;
    } directed_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [lsag_pkg::IN_DATA_W-1:0]      s_tdata;
    logic [lsag_pkg::IN_USER_W-1:0]      s_tuser;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [lsag_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                                m_tlast;

    transfer_t               expected_transfers[$];
    directed_row_t           directed_rows[25];
    int                      mismatches = 0;
    int                      cycle_count = 0;
    int                      ready_hold = 0;
    logic                    steady = 1'b0;

    load_store_address_generator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_fault(logic [1:0] code);
        transfer_t e;
        e = '0;
        e.res.fault = code;
        e.last = 1'b1;
        expected_transfers.push_back(e);
    endfunction

    // Works out every transfer that one instruction causes and queues it.
    function automatic void predict_transfers(ls_instr_t it);
        logic [31:0] ins;
        logic [31:0] offset;
        logic [31:0] rnv;
        logic [31:0] addr;
        logic [31:0] wbv;
        logic [31:0] span;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [4:0]  amt;
        logic [2:0]  wpu;
        logic [1:0]  size;
        logic        half;
        logic        imm;
        logic        same;
        logic        wb;
        int          count;
        int          k;
        transfer_t   e;

        ins  = it.ins;
        rn   = ins[19:16];
        rm   = ins[3:0];
        same = 1'b0;
        wb   = 1'b0;
        wbv  = '0;

        // Block transfer: one result per listed register, lowest first, or one for an empty list.
        if (it.fn == lsag_pkg::FUNC_MULTIPLE)
        begin
            if (ins[22] && !it.spsr)
            begin
                push_fault(lsag_pkg::FAULT_ABORT);
                return;
            end
            count = $countones(ins[15:0]);
            span  = 32'(count * 4);
            wb    = ins[21];
            case (ins[24:23])
                2'b01:
                begin
                    addr = it.base;
                    wbv  = it.base + span;
                end
                2'b11:
                begin
                    addr = it.base + 32'd4;
                    wbv  = it.base + span;
                end
                2'b00:
                begin
                    addr = it.base - span + 32'd4;
                    wbv  = it.base - span;
                end
                default:
                begin
                    addr = it.base - span;
                    wbv  = it.base - span;
                end
            endcase
            if (count == 0)
            begin
                e = '0;
                e.res.base_writeback  = wb;
                e.res.writeback_value = wb ? wbv : '0;
                e.last = 1'b1;
                expected_transfers.push_back(e);
                return;
            end
            k = 0;
            for (int i = 0; i < 16; i++)
            begin
                if (ins[i])
                begin
                    k++;
                    e = '0;
                    e.res.transfer_valid   = 1'b1;
                    e.res.is_load          = ins[20];
                    e.res.access_size      = lsag_pkg::SIZE_WORD;
                    e.res.transfer_address = addr;
                    e.res.reg_index        = 4'(i);
                    e.res.base_writeback   = wb;
                    e.res.writeback_value  = wb ? wbv : '0;
                    e.last = (k == count);
                    expected_transfers.push_back(e);
                    addr = addr + 32'd4;
                end
            end
            return;
        end

        if (it.fn != lsag_pkg::FUNC_SINGLE)
        begin
            push_fault(lsag_pkg::FAULT_UNDEF);
            return;
        end

        // Decode the single transfer class.
        if (ins[27:25] == lsag_pkg::OP_HALF)
        begin
            if (ins[7:4] != lsag_pkg::HALF_MARK)
            begin
                push_fault(lsag_pkg::FAULT_UNDEF);
                return;
            end
            half = 1'b1;
            imm  = ins[22];
            size = lsag_pkg::SIZE_HALF;
        end
        else if (ins[27:25] == lsag_pkg::OP_IMM || ins[27:25] == lsag_pkg::OP_REG)
        begin
            half = 1'b0;
            imm  = !ins[25];
            size = ins[22] ? lsag_pkg::SIZE_BYTE : lsag_pkg::SIZE_WORD;
        end
        else
        begin
            push_fault(lsag_pkg::FAULT_UNDEF);
            return;
        end

        // Offset: immediate, plain register, or scaled register.
        if (imm)
        begin
            offset = half ? {24'd0, ins[11:8], ins[3:0]} : {20'd0, ins[11:0]};
        end
        else
        begin
            if (rm == lsag_pkg::REG_PC)
            begin
                push_fault(lsag_pkg::FAULT_ABORT);
                return;
            end
            same = (rn == rm);
            if (!half && ins[11:4] != 8'd0)
            begin
                amt = ins[11:7];
                case (ins[6:5])
                    lsag_pkg::SHIFT_LSL: offset = it.rmv << amt;
                    lsag_pkg::SHIFT_LSR: offset = (amt == 5'd0) ? 32'd0 : it.rmv >> amt;
                    lsag_pkg::SHIFT_ASR: offset = (amt == 5'd0) ? {32{it.rmv[31]}}
                                                  : $unsigned($signed(it.rmv) >>> amt);
                    default:   offset = (amt == 5'd0) ? {it.carry, it.rmv[31:1]}
                                                      : (it.rmv >> amt)
                                                        | (it.rmv << (6'd32 - amt));
                endcase
            end
            else
            begin
                offset = it.rmv;
            end
        end

        // Addressing mode from W, P and U.
        rnv = (rn == lsag_pkg::REG_PC) ? it.base + 32'd8 : it.base;
        wpu = {ins[21], ins[24], ins[23]};
        case (wpu)
            3'd3: addr = rnv + offset;
            3'd2: addr = rnv - offset;
            3'd7, 3'd6, 3'd1, 3'd0:
            begin
                if (rn == lsag_pkg::REG_PC || same)
                begin
                    push_fault(lsag_pkg::FAULT_ABORT);
                    return;
                end
                wbv  = wpu[0] ? rnv + offset : rnv - offset;
                addr = wpu[1] ? wbv : rnv;
                wb   = 1'b1;
            end
            default:
            begin
                push_fault(lsag_pkg::FAULT_ABORT);
                return;
            end
        endcase

        if (half && addr[0])
        begin
            push_fault(lsag_pkg::FAULT_ABORT);
            return;
        end

        e = '0;
        e.res.transfer_valid   = 1'b1;
        e.res.is_load          = ins[20];
        e.res.access_size      = size;
        e.res.transfer_address = addr;
        e.res.reg_index        = ins[15:12];
        e.res.base_writeback   = wb;
        e.res.writeback_value  = wbv;
        e.res.fault            = lsag_pkg::FAULT_NONE;
        e.last = 1'b1;
        expected_transfers.push_back(e);
    endfunction

    // Random instruction: mostly well-formed transfers, some noise.
    function automatic ls_instr_t random_instr();
        ls_instr_t it;
        int        r;
        int        density;

        r        = $urandom_range(0, 99);
        it.ins   = $urandom;
        it.base  = $urandom;
        it.rmv   = $urandom;
        it.carry = 1'($urandom);
        it.spsr  = 1'($urandom);
        if (r < 8)
        begin
            it.fn = $urandom_range(0, 1) ? FUNC_COPROC : FUNC_RESERVED;
        end
        else if (r < 12)
        begin
            it.fn = lsag_pkg::FUNC_SINGLE;
        end
        else if (r < 55)
        begin
            it.fn = lsag_pkg::FUNC_SINGLE;
            case ($urandom_range(0, 2))
                0:
                begin
                    it.ins[27:25] = lsag_pkg::OP_HALF;
                    it.ins[7:4]   = lsag_pkg::HALF_MARK;
                end
                1:       it.ins[27:25] = lsag_pkg::OP_IMM;
                default: it.ins[27:25] = lsag_pkg::OP_REG;
            endcase
            // Keep most halfword addresses even so that they get past the alignment check.
            if (it.ins[27:25] == lsag_pkg::OP_HALF && $urandom_range(0, 3) != 0)
            begin
                it.base[0] = 1'b0;
                if (it.ins[22])
                    it.ins[0] = 1'b0;
                else
                    it.rmv[0] = 1'b0;
            end
            // Translated forms abort, so make them less common.
            if (!it.ins[24] && $urandom_range(0, 3) != 0)
                it.ins[21] = 1'b0;
        end
        else
        begin
            it.fn = lsag_pkg::FUNC_MULTIPLE;
            density = $urandom_range(0, 3);
            if (density == 0)
                it.ins[15:0] = 16'($urandom & $urandom & $urandom);
            else if (density == 1)
                it.ins[15:0] = 16'($urandom & $urandom);
            else if (density == 2)
                it.ins[15:0] = 16'(1 << $urandom_range(0, 15)) & 16'($urandom);
            if (it.ins[22] && $urandom_range(0, 3) != 0)
                it.spsr = 1'b1;
        end
        return it;
    endfunction

    // Presents one item, waits for it to be taken, then idles for a picked gap, which may be none.
    task automatic drive_item(ls_instr_t it, logic typed, logic [1:0] typed_fault);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.spsr, it.carry, it.rmv, it.base, it.ins};
        s_tuser  <= it.fn;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (typed)
            push_fault(typed_fault);
        else
            predict_transfers(it);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checking and receiver stalls.
    always @(posedge clk)
    begin : collect
        transfer_t         want;
        lsag_pkg::result_t got;
        int                hold;
        if (m_tvalid && m_tready)
        begin
            got = lsag_pkg::result_t'(m_tdata[$bits(lsag_pkg::result_t)-1:0]);
            if (expected_transfers.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, got %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_transfers.pop_front();
                check_field("transfer_valid", 32'(want.res.transfer_valid),
                            32'(got.transfer_valid));
                check_field("is_load", 32'(want.res.is_load), 32'(got.is_load));
                check_field("access_size", 32'(want.res.access_size), 32'(got.access_size));
                check_field("transfer_address", want.res.transfer_address,
                            got.transfer_address);
                check_field("reg_index", 32'(want.res.reg_index), 32'(got.reg_index));
                check_field("base_writeback", 32'(want.res.base_writeback),
                            32'(got.base_writeback));
                check_field("writeback_value", want.res.writeback_value,
                            got.writeback_value);
                check_field("fault", 32'(want.res.fault), 32'(got.fault));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
        if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                ready_hold = hold - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_load_store_address_generator: errors");
            $finish;
        end
    end

    initial
    begin
        // Fault rows have their result typed in; the rest go through the predictor.
        directed_rows = '{
            '{'{FUNC_COPROC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_UNDEF},
            '{'{FUNC_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
              1'b1, lsag_pkg::FAULT_UNDEF},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0200_0000, 32'h0000_1000, 32'h0, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_UNDEF},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0000_0090, 32'h0000_1000, 32'h0, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_UNDEF},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0780_000F, 32'h0000_1000, 32'h4, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_ABORT},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h05AF_0000, 32'h0000_1000, 32'h0, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_ABORT},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h07A3_0003, 32'h0000_1000, 32'h8, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_ABORT},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0420_0000, 32'h0000_1000, 32'h0, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_ABORT},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h01C0_00B1, 32'h0000_1000, 32'h0, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_ABORT},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h08C0_FFFF, 32'h0000_1000, 32'h0, 1'b0, 1'b0},
              1'b1, lsag_pkg::FAULT_ABORT},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0180_00B2, 32'h0000_2000, 32'h10, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0790_0021, 32'h0000_0100, 32'hFFFF_FFFF,
                1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0790_0041, 32'h0000_0100, 32'h8000_0000,
                1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0790_0061, 32'h0000_0100, 32'h1234_5679,
                1'b1, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0790_0F81, 32'h0000_0100, 32'h0000_0001,
                1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h059F_0004, 32'h0000_8000, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h0410_0010, 32'h0000_0100, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h05E1_2FFF, 32'hFFFF_F000, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h08A0_0000, 32'h0000_0400, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h08B0_FFFF, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h0920_0005, 32'h0000_0100, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h0990_0300, 32'h0000_0200, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h0810_8001, 32'h0000_0300, 32'h0, 1'b0, 1'b0},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_SINGLE, 32'h07B1_F00E, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                1'b1, 1'b1},
              1'b0, lsag_pkg::FAULT_NONE},
            '{'{lsag_pkg::FUNC_MULTIPLE, 32'h09D0_8000, 32'h0000_1000, 32'h0, 1'b0, 1'b1},
              1'b0, lsag_pkg::FAULT_NONE}
        };

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows.
        foreach (directed_rows[i])
            drive_item(directed_rows[i].item, directed_rows[i].typed,
                       directed_rows[i].typed_fault);

        // Hold the sender until the block has delivered everything it owes.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_transfers.size() != 0)
            @(posedge clk);

        // Random items, with a stretch in the middle where neither side idles.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 90 && n < 140);
            drive_item(random_instr(), 1'b0, lsag_pkg::FAULT_NONE);
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_transfers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("tb_load_store_address_generator: clean");
        else
            $display("tb_load_store_address_generator: errors");
        $finish;
    end

endmodule
